/* rtl/sfsim_pkg.sv */
// Shared types, codes and sizes for the stuck-at fault netlist simulator.
// Used by every module in the rtl folder; depends on nothing else.
`default_nettype none

package sfsim_pkg;

    // Grid geometry and limits.
    localparam int GRID_ROWS   = 8;
    localparam int GRID_COLS   = 8;
    localparam int ROW_W       = 3;
    localparam int COL_W       = 3;
    localparam int CELLS       = GRID_ROWS * GRID_COLS;
    localparam int IDX_W       = ROW_W + COL_W;
    localparam int MAX_FANIN   = 4;
    localparam int FANIN_W     = 3;
    localparam int MAX_OUTPUTS = 8;
    localparam int OUT_IDX_W   = 3;
    localparam int CNT_W       = 4;
    localparam int VEC_W       = 8;

    // Operation codes.
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_EVAL   = 2'd2;

    // Gate type codes.
    localparam logic [3:0] GT_EMPTY = 4'd0;
    localparam logic [3:0] GT_AND   = 4'd1;
    localparam logic [3:0] GT_OR    = 4'd2;
    localparam logic [3:0] GT_NOT   = 4'd3;
    localparam logic [3:0] GT_XOR   = 4'd4;
    localparam logic [3:0] GT_NAND  = 4'd5;
    localparam logic [3:0] GT_NOR   = 4'd6;
    localparam logic [3:0] GT_XNOR  = 4'd7;
    localparam logic [3:0] GT_BUF   = 4'd8;
    localparam logic [3:0] GT_INPUT = 4'd9;

    // Status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_SRC = 3'd1;
    localparam logic [2:0] ST_NO_GATE = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_NO_OUTS = 3'd4;

    // Three-valued logic codes.
    localparam logic [1:0] V_ZERO = 2'd0;
    localparam logic [1:0] V_ONE  = 2'd1;
    localparam logic [1:0] V_UNK  = 2'd2;

    // Command transaction payload.
    typedef struct packed {
        logic [1:0]       op;
        logic [ROW_W-1:0] gate_row;
        logic [COL_W-1:0] gate_col;
        logic [3:0]       gate_type;
        logic [2:0]       fanin_count;
        logic [IDX_W-1:0] source_a;
        logic [IDX_W-1:0] source_b;
        logic [IDX_W-1:0] source_c;
        logic [IDX_W-1:0] source_d;
        logic [VEC_W-1:0] input_vector;
        logic             fault_enable;
        logic             fault_value;
    } t_cmd;

    // Result transaction payload.
    typedef struct packed {
        logic [2:0]           status;
        logic [OUT_IDX_W-1:0] output_index;
        logic [1:0]           good_value;
        logic [1:0]           faulty_value;
        logic                 fault_detected;
        logic                 last;
    } t_result;

    // One gate table entry: 31 bits.
    typedef struct packed {
        logic [3:0]                      gtype;
        logic [FANIN_W-1:0]              fanin;
        logic [MAX_FANIN-1:0][IDX_W-1:0] src;
    } t_gate;

    // Good and faulty values of one grid node, kept in one memory word.
    typedef struct packed {
        logic [1:0] faulty;
        logic [1:0] good;
    } t_vpair;

    // Control from the sequencer to the gate evaluator.
    typedef struct packed {
        logic load;
        logic use_a;
        logic use_b;
        logic use_c;
        logic use_d;
    } t_eval_ctl;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_RD_AB,
        S_RD_CD,
        S_WRITE,
        S_OUT_RD,
        S_OUT_EMIT
    } t_state;

endpackage

`default_nettype wire

/* rtl/stuck_at_fault_netlist_simulator.sv */
// Stuck-at fault netlist simulator: 8x8 levelized gate grid, good and faulty sweep.
// Load and append: one result in the cycle after acceptance, back to back.
// Evaluate: a fault-site check, then for each of the 64 grid nodes two value-memory read
// pairs and a write back, then a read and an emit for each listed output, then back to
// idle; the node sweep is limited by the two read ports of the value memory.
// Synchronous active-low reset empties the gate table and output list; no receiver stall.
`default_nettype none

module stuck_at_fault_netlist_simulator
    import sfsim_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_cmd i_cmd,
    output logic      busy,
    output logic      o_valid,
    output t_result   o_result
);

    t_state                r_state;
    t_state                n_state;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      n_idx;
    logic [OUT_IDX_W-1:0]  r_k;
    logic [OUT_IDX_W-1:0]  n_k;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    logic                  r_valid;
    logic                  n_valid;
    t_result               r_res;
    t_result               n_res;
    logic [IDX_W-1:0]      r_olist [MAX_OUTPUTS];
    logic [IDX_W-1:0]      r_site;
    logic [VEC_W-1:0]      r_vec;
    logic                  r_fen;
    logic                  r_fval;

    logic [IDX_W-1:0]      in_site;
    logic [FANIN_W-1:0]    in_fanin;
    t_gate                 in_gate;
    logic                  bad_src;
    logic                  accept;
    logic                  ol_we;

    logic                  gm_we;
    logic [IDX_W-1:0]      gm_raddr;
    t_gate                 gm_rdata;
    logic                  vm_we;
    logic [IDX_W-1:0]      vm_raddr0;
    logic [IDX_W-1:0]      vm_raddr1;
    t_vpair                vm_rdata0;
    t_vpair                vm_rdata1;
    t_vpair                ev_value;
    t_eval_ctl             ev_ctl;

    assign accept  = start && !busy;
    assign in_site = {i_cmd.gate_row, i_cmd.gate_col};

    // Fan-in saturates at the table limit.
    assign in_fanin = (i_cmd.fanin_count > FANIN_W'(MAX_FANIN)) ?
                      FANIN_W'(MAX_FANIN) : i_cmd.fanin_count;

    assign in_gate = '{gtype: i_cmd.gate_type, fanin: in_fanin,
                       src: {i_cmd.source_d, i_cmd.source_c,
                             i_cmd.source_b, i_cmd.source_a}};

    // Every used source must sit in a strictly earlier row.
    always_comb begin
        bad_src = 1'b0;
        for (int i = 0; i < MAX_FANIN; i++) begin
            if ((FANIN_W'(i) < in_fanin) &&
                (in_gate.src[i][IDX_W-1:COL_W] >= i_cmd.gate_row)) begin
                bad_src = 1'b1;
            end
        end
    end

    sfsim_gate_mem u_gate_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (gm_we),
        .i_waddr (in_site),
        .i_wdata (in_gate),
        .i_raddr (gm_raddr),
        .o_rdata (gm_rdata)
    );

    sfsim_val_mem u_val_mem (
        .i_clk    (i_clk),
        .i_we     (vm_we),
        .i_waddr  (r_idx),
        .i_wdata  (ev_value),
        .i_raddr0 (vm_raddr0),
        .i_raddr1 (vm_raddr1),
        .o_rdata0 (vm_rdata0),
        .o_rdata1 (vm_rdata1)
    );

    sfsim_eval u_eval (
        .i_clk       (i_clk),
        .i_ctl       (ev_ctl),
        .i_src0      (vm_rdata0),
        .i_src1      (vm_rdata1),
        .i_gate      (gm_rdata),
        .i_idx       (r_idx),
        .i_site      (r_site),
        .i_vec       (r_vec),
        .i_fault_en  (r_fen),
        .i_fault_val (r_fval),
        .o_value     (ev_value)
    );

    // Sequencer: next state, memory addresses and result formation.
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_k       = r_k;
        n_cnt     = r_cnt;
        n_valid   = 1'b0;
        n_res     = '0;
        gm_we     = 1'b0;
        gm_raddr  = r_idx;
        vm_we     = 1'b0;
        vm_raddr0 = gm_rdata.src[0];
        vm_raddr1 = gm_rdata.src[1];
        ev_ctl    = '0;
        ol_we     = 1'b0;
        case (r_state)
            S_IDLE: begin
                gm_raddr = in_site;
                if (accept) begin
                    n_res.last = 1'b1;
                    case (i_cmd.op)
                        OP_LOAD: begin
                            n_valid = 1'b1;
                            if (bad_src) begin
                                n_res.status = ST_BAD_SRC;
                            end else begin
                                gm_we = 1'b1;
                            end
                        end
                        OP_APPEND: begin
                            n_valid = 1'b1;
                            if (r_cnt >= CNT_W'(MAX_OUTPUTS)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                ol_we              = 1'b1;
                                n_res.output_index = r_cnt[OUT_IDX_W-1:0];
                                n_cnt              = r_cnt + CNT_W'(1);
                            end
                        end
                        OP_EVAL: begin
                            if (r_cnt == '0) begin
                                n_valid      = 1'b1;
                                n_res.status = ST_NO_OUTS;
                            end else begin
                                n_state = S_CHK;
                            end
                        end
                        default: begin
                            n_res = '0;
                        end
                    endcase
                end
            end
            S_CHK: begin
                // Gate at the fault site is on the read port now.
                if (r_fen && (gm_rdata.gtype == GT_EMPTY)) begin
                    n_valid      = 1'b1;
                    n_res.status = ST_NO_GATE;
                    n_res.last   = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    gm_raddr = '0;
                    n_idx    = '0;
                    n_state  = S_RD_AB;
                end
            end
            S_RD_AB: begin
                n_state = S_RD_CD;
            end
            S_RD_CD: begin
                vm_raddr0    = gm_rdata.src[2];
                vm_raddr1    = gm_rdata.src[3];
                ev_ctl.load  = 1'b1;
                ev_ctl.use_a = gm_rdata.fanin > FANIN_W'(0);
                ev_ctl.use_b = gm_rdata.fanin > FANIN_W'(1);
                n_state      = S_WRITE;
            end
            S_WRITE: begin
                ev_ctl.use_c = gm_rdata.fanin > FANIN_W'(2);
                ev_ctl.use_d = gm_rdata.fanin > FANIN_W'(3);
                vm_we        = 1'b1;
                gm_raddr     = r_idx + IDX_W'(1);
                if (r_idx == IDX_W'(CELLS - 1)) begin
                    n_k     = '0;
                    n_state = S_OUT_RD;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_RD_AB;
                end
            end
            S_OUT_RD: begin
                vm_raddr0 = r_olist[r_k];
                n_state   = S_OUT_EMIT;
            end
            S_OUT_EMIT: begin
                n_valid              = 1'b1;
                n_res.output_index   = r_k;
                n_res.good_value     = vm_rdata0.good;
                n_res.faulty_value   = vm_rdata0.faulty;
                n_res.fault_detected = vm_rdata0.good != vm_rdata0.faulty;
                n_res.last           = ({1'b0, r_k} + CNT_W'(1)) == r_cnt;
                if (n_res.last) begin
                    n_state = S_IDLE;
                end else begin
                    n_k     = r_k + OUT_IDX_W'(1);
                    n_state = S_OUT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    // Payload registers: counters, captured evaluate command, output list.
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_k   <= n_k;
        r_res <= n_res;
        if (accept) begin
            r_site <= in_site;
            r_vec  <= i_cmd.input_vector;
            r_fen  <= i_cmd.fault_enable;
            r_fval <= i_cmd.fault_value;
        end
        if (ol_we) begin
            r_olist[r_cnt[OUT_IDX_W-1:0]] <= in_site;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

`default_nettype wire

/* rtl/sfsim_gate_mem.sv */
// Gate table memory: one write port, one registered read port.
// Per-entry valid bits make never-loaded entries read as empty. Uses sfsim_pkg.
`default_nettype none

module sfsim_gate_mem
    import sfsim_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire t_gate            i_wdata,
    input  wire logic [IDX_W-1:0] i_raddr,
    output t_gate                 o_rdata
);

    t_gate            r_mem [CELLS];
    logic [CELLS-1:0] r_valid;
    t_gate            r_rdata;
    logic             r_rvalid;

    // Storage array and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // Valid bits, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    // An entry never loaded reads as an empty gate.
    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

`default_nettype wire

/* rtl/sfsim_val_mem.sv */
// Node value memory holding good and faulty values side by side.
// One write port and two registered read ports. Uses sfsim_pkg.
`default_nettype none

module sfsim_val_mem
    import sfsim_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire t_vpair           i_wdata,
    input  wire logic [IDX_W-1:0] i_raddr0,
    input  wire logic [IDX_W-1:0] i_raddr1,
    output t_vpair                o_rdata0,
    output t_vpair                o_rdata1
);

    t_vpair r_mem [CELLS];
    t_vpair r_rdata0;
    t_vpair r_rdata1;

    // Write and two registered reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

`default_nettype wire

/* rtl/sfsim_eval.sv */
// Gate evaluator: gathers source values two at a time and forms the new
// good and faulty node values, with the stuck-at fault applied. Uses sfsim_pkg.
`default_nettype none

module sfsim_eval
    import sfsim_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_eval_ctl        i_ctl,
    input  wire t_vpair           i_src0,
    input  wire t_vpair           i_src1,
    input  wire t_gate            i_gate,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire logic [IDX_W-1:0] i_site,
    input  wire logic [VEC_W-1:0] i_vec,
    input  wire logic             i_fault_en,
    input  wire logic             i_fault_val,
    output t_vpair                o_value
);

    // Summary of the sources seen so far for one copy of the circuit.
    typedef struct packed {
        logic zero;
        logic one;
        logic unk;
        logic par;
    } t_acc;

    localparam t_acc ACC_EMPTY = '0;

    t_acc r_acc_g;
    t_acc r_acc_f;
    t_acc n_acc_g;
    t_acc n_acc_f;
    t_acc fin_g;
    t_acc fin_f;
    logic [1:0] val_g;
    logic [1:0] val_f;

    function automatic t_acc acc_add(t_acc a, logic [1:0] v, logic en);
        t_acc r;
        r = a;
        if (en) begin
            r.zero = a.zero | (v == V_ZERO);
            r.one  = a.one  | (v == V_ONE);
            r.unk  = a.unk  | (v[1] == 1'b1);
            r.par  = a.par  ^ v[0];
        end
        return r;
    endfunction

    function automatic logic [1:0] gate_out(t_gate g, logic [IDX_W-1:0] idx,
                                            logic [VEC_W-1:0] vec, t_acc a);
        logic [1:0] r;
        logic       single;
        single = (g.fanin == FANIN_W'(1));
        r = V_UNK;
        case (g.gtype)
            GT_AND:  r = a.zero ? V_ZERO : V_ONE;
            GT_NAND: r = a.zero ? V_ONE : V_ZERO;
            GT_OR:   r = a.one ? V_ONE : V_ZERO;
            GT_NOR:  r = a.one ? V_ZERO : V_ONE;
            GT_XOR:  r = a.unk ? V_UNK : {1'b0, a.par};
            GT_XNOR: r = a.unk ? V_UNK : {1'b0, ~a.par};
            GT_NOT:  r = (!single || a.unk) ? V_UNK : (a.zero ? V_ONE : V_ZERO);
            GT_BUF:  r = (!single || a.unk) ? V_UNK : (a.one ? V_ONE : V_ZERO);
            GT_INPUT: begin
                // Only the row-0 input gates see the input vector.
                if (idx[IDX_W-1:COL_W] == '0) begin
                    r = {1'b0, vec[idx[COL_W-1:0]]};
                end
            end
            default: r = V_UNK;
        endcase
        return r;
    endfunction

    // First pair of sources starts a fresh summary.
    always_comb begin
        n_acc_g = r_acc_g;
        n_acc_f = r_acc_f;
        if (i_ctl.load) begin
            n_acc_g = acc_add(acc_add(ACC_EMPTY, i_src0.good, i_ctl.use_a),
                              i_src1.good, i_ctl.use_b);
            n_acc_f = acc_add(acc_add(ACC_EMPTY, i_src0.faulty, i_ctl.use_a),
                              i_src1.faulty, i_ctl.use_b);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc_g <= n_acc_g;
        r_acc_f <= n_acc_f;
    end

    // Second pair of sources closes the summary and gives the node value.
    always_comb begin
        fin_g = acc_add(acc_add(r_acc_g, i_src0.good, i_ctl.use_c),
                        i_src1.good, i_ctl.use_d);
        fin_f = acc_add(acc_add(r_acc_f, i_src0.faulty, i_ctl.use_c),
                        i_src1.faulty, i_ctl.use_d);
        val_g = gate_out(i_gate, i_idx, i_vec, fin_g);
        val_f = gate_out(i_gate, i_idx, i_vec, fin_f);
        if (i_fault_en && (i_idx == i_site)) begin
            val_f = {1'b0, i_fault_val};
        end
    end

    assign o_value = '{faulty: val_f, good: val_g};

endmodule

`default_nettype wire

/* dv/sfsim_result_checker.sv */
// Result checker for the stuck-at fault netlist simulator: watches the command and
// result channels, predicts every result and compares it field by field.
// Depends on sfsim_pkg for the transaction types, codes and grid sizes.

module sfsim_result_checker
    import sfsim_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_cmd    i_cmd,
    input  logic    i_busy,
    input  logic    i_valid,
    input  t_result i_result,
    output int      o_errors,
    output int      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the gate grid, the node values and the output list.
    logic [3:0]         cell_type  [CELLS];
    logic [FANIN_W-1:0] cell_fanin [CELLS];
    logic [IDX_W-1:0]   cell_src   [CELLS][MAX_FANIN];
    logic [1:0]         good_net   [CELLS];
    logic [1:0]         faulty_net [CELLS];
    logic [IDX_W-1:0]   watch_list [MAX_OUTPUTS];
    int unsigned        watch_count;

    // Results still owed by the block, oldest first.
    t_result pending_results [$];
    int      mismatches = 0;

    assign o_errors = mismatches;

    function automatic t_result make_result(logic [2:0] st, int unsigned idx,
                                            logic [1:0] g, logic [1:0] f, logic last);
        t_result r;
        r.status         = st;
        r.output_index   = OUT_IDX_W'(idx);
        r.good_value     = g;
        r.faulty_value   = f;
        r.fault_detected = (g != f);
        r.last           = last;
        return r;
    endfunction

    // Single result for loads, rejected appends and rejected evaluates.
    function automatic void push_status(logic [2:0] st);
        pending_results.push_back(make_result(st, 0, V_ZERO, V_ZERO, 1'b1));
    endfunction

    // Three-valued value of one node, from the good or the faulty copy.
    function automatic logic [1:0] node_value(int unsigned idx, bit use_faulty,
                                              logic [VEC_W-1:0] vec);
        logic [1:0]  v [MAX_FANIN];
        int unsigned n;
        logic        acc;
        bit          unk;
        n   = cell_fanin[idx];
        acc = 1'b0;
        unk = 1'b0;
        for (int i = 0; i < MAX_FANIN; i++) begin
            v[i] = use_faulty ? faulty_net[cell_src[idx][i]] : good_net[cell_src[idx][i]];
        end
        case (cell_type[idx])
            GT_AND, GT_NAND: begin
                // Unknown inputs do not force a zero.
                acc = 1'b1;
                for (int i = 0; i < n; i++) if (v[i] == V_ZERO) acc = 1'b0;
                return {1'b0, acc ^ (cell_type[idx] == GT_NAND)};
            end
            GT_OR, GT_NOR: begin
                // Unknown inputs do not force a one.
                for (int i = 0; i < n; i++) if (v[i] == V_ONE) acc = 1'b1;
                return {1'b0, acc ^ (cell_type[idx] == GT_NOR)};
            end
            GT_XOR, GT_XNOR: begin
                for (int i = 0; i < n; i++) begin
                    if (v[i] == V_UNK) unk = 1'b1;
                    acc ^= v[i][0];
                end
                return unk ? V_UNK : {1'b0, acc ^ (cell_type[idx] == GT_XNOR)};
            end
            GT_NOT: begin
                return (n != 1 || v[0] == V_UNK) ? V_UNK : {1'b0, ~v[0][0]};
            end
            GT_BUF: begin
                return (n != 1) ? V_UNK : v[0];
            end
            GT_INPUT: begin
                // Only the first row of the grid is wired to the input vector.
                return (idx < GRID_COLS && idx < VEC_W) ? {1'b0, vec[idx]} : V_UNK;
            end
            default: begin
                return V_UNK;
            end
        endcase
    endfunction

    // Update the shadow state for one accepted transaction and queue its results.
    task automatic predict_command(input t_cmd c);
        logic [IDX_W-1:0] srcs [MAX_FANIN];
        int unsigned      site;
        int unsigned      n;
        bit               in_grid;
        bit               bad_src;
        logic [1:0]       g;
        logic [1:0]       f;
        in_grid = (c.gate_row < GRID_ROWS) && (c.gate_col < GRID_COLS);
        site    = c.gate_row * GRID_COLS + c.gate_col;
        srcs    = '{c.source_a, c.source_b, c.source_c, c.source_d};
        n       = (c.fanin_count > MAX_FANIN) ? MAX_FANIN : c.fanin_count;
        bad_src = 1'b0;
        case (c.op)
            OP_LOAD: begin
                // Every used source must sit in a strictly earlier row.
                for (int i = 0; i < n; i++) begin
                    if (srcs[i] / GRID_COLS >= c.gate_row) bad_src = 1'b1;
                end
                if (!in_grid) begin
                    push_status(ST_NO_GATE);
                end else if (bad_src) begin
                    push_status(ST_BAD_SRC);
                end else begin
                    cell_type[site]  = c.gate_type;
                    cell_fanin[site] = FANIN_W'(n);
                    for (int i = 0; i < MAX_FANIN; i++) cell_src[site][i] = srcs[i];
                    push_status(ST_OK);
                end
            end
            OP_APPEND: begin
                if (watch_count >= MAX_OUTPUTS) begin
                    push_status(ST_FULL);
                end else if (!in_grid) begin
                    push_status(ST_NO_GATE);
                end else begin
                    watch_list[watch_count] = IDX_W'(site);
                    pending_results.push_back(make_result(ST_OK, watch_count,
                                                          V_ZERO, V_ZERO, 1'b1));
                    watch_count++;
                end
            end
            OP_EVAL: begin
                if (watch_count == 0) begin
                    push_status(ST_NO_OUTS);
                end else if (c.fault_enable && (!in_grid || cell_type[site] == GT_EMPTY)) begin
                    push_status(ST_NO_GATE);
                end else begin
                    // Sweep both copies in flat order, which is also row order.
                    for (int unsigned i = 0; i < CELLS; i++) begin
                        good_net[i] = node_value(i, 1'b0, c.input_vector);
                        if (c.fault_enable && i == site) begin
                            faulty_net[i] = {1'b0, c.fault_value};
                        end else begin
                            faulty_net[i] = node_value(i, 1'b1, c.input_vector);
                        end
                    end
                    for (int unsigned k = 0; k < watch_count; k++) begin
                        g = good_net[watch_list[k]];
                        f = faulty_net[watch_list[k]];
                        pending_results.push_back(make_result(ST_OK, k, g, f,
                                                              k + 1 == watch_count));
                    end
                end
            end
            default: begin
                // The unused operation is dropped without a result.
            end
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("result field %s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (pending_results.size() == 0) begin
            $error("unexpected result transaction: status %0d, output_index %0d",
                   got.status, got.output_index);
            mismatches++;
        end else begin
            want = pending_results.pop_front();
            check_field("status", want.status, got.status);
            check_field("output_index", want.output_index, got.output_index);
            check_field("good_value", want.good_value, got.good_value);
            check_field("faulty_value", want.faulty_value, got.faulty_value);
            check_field("fault_detected", want.fault_detected, got.fault_detected);
            check_field("last", want.last, got.last);
        end
    endtask

    // Both channels are sampled at the clock edge; results are checked before the
    // transaction accepted at the same edge adds its own expectations.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) begin
                cell_type[i]  = GT_EMPTY;
                cell_fanin[i] = '0;
                good_net[i]   = V_UNK;
                faulty_net[i] = V_UNK;
                for (int j = 0; j < MAX_FANIN; j++) cell_src[i][j] = '0;
            end
            watch_count = 0;
            pending_results.delete();
        end else begin
            if (i_valid) check_result(i_result);
            if (i_start && !i_busy) predict_command(i_cmd);
        end
        o_pending = pending_results.size();
    end

endmodule

/* dv/tb.sv */
// Top of the stuck-at fault netlist simulator testbench: clock, reset, command
// stimulus and the final verdict. Depends on sfsim_pkg, the block and
// sfsim_result_checker, which does all prediction and comparison.

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sfsim_pkg::*;

    localparam int         RANDOM_ITEMS  = 295;
    localparam int         CALM_TAIL     = 40;
    localparam int         DRAIN_CYCLES  = 300;
    localparam int         LIMIT_NS      = 6_000_000;
    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam logic [3:0] GT_UNUSED_TOP = 4'd15;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd    cmd     = '0;
    logic    busy;
    logic    o_valid;
    t_result o_result;
    int      errors;
    int      pending;
    bit      gaps_on = 1'b1;

    always #6 i_clk = ~i_clk;

    stuck_at_fault_netlist_simulator DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (cmd),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    sfsim_result_checker u_results (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_cmd     (cmd),
        .i_busy    (busy),
        .i_valid   (o_valid),
        .i_result  (o_result),
        .o_errors  (errors),
        .o_pending (pending)
    );

    // Command with every field random except the operation.
    function automatic t_cmd random_cmd(logic [1:0] op);
        t_cmd        c;
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        c    = bits[$bits(t_cmd)-1:0];
        c.op = op;
        return c;
    endfunction

    // Gate load; a legal one draws its used sources from earlier rows only.
    function automatic t_cmd random_load(bit legal);
        t_cmd             c;
        logic [IDX_W-1:0] srcs [MAX_FANIN];
        int unsigned      row;
        int unsigned      n;
        c    = random_cmd(OP_LOAD);
        row  = c.gate_row;
        srcs = '{c.source_a, c.source_b, c.source_c, c.source_d};
        if (row == 0) begin
            c.fanin_count = '0;
            if ($urandom_range(0, 9) < 7) c.gate_type = GT_INPUT;
        end else begin
            if ($urandom_range(0, 9) < 8) c.gate_type = 4'($urandom_range(1, 8));
            if ($urandom_range(0, 4) != 0) c.fanin_count = 3'($urandom_range(1, 4));
        end
        n = (c.fanin_count > MAX_FANIN) ? MAX_FANIN : c.fanin_count;
        if (row != 0) begin
            for (int i = 0; i < n; i++) srcs[i] = IDX_W'($urandom_range(0, row * GRID_COLS - 1));
        end
        if (!legal) begin
            if (n == 0) begin
                c.fanin_count = 3'($urandom_range(1, 7));
                n = (c.fanin_count > MAX_FANIN) ? MAX_FANIN : c.fanin_count;
            end
            srcs[$urandom_range(0, n - 1)] = IDX_W'($urandom_range(row * GRID_COLS, CELLS - 1));
        end
        c.source_a = srcs[0];
        c.source_b = srcs[1];
        c.source_c = srcs[2];
        c.source_d = srcs[3];
        return c;
    endfunction

    function automatic t_cmd random_eval();
        t_cmd c;
        c = random_cmd(OP_EVAL);
        c.fault_enable = ($urandom_range(0, 4) != 0);
        return c;
    endfunction

    // Present one command transaction, hold it until accepted, then maybe idle.
    task automatic issue(input t_cmd c);
        start <= 1'b1;
        cmd   <= c;
        do @(posedge i_clk); while (busy);
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // Hold off until every predicted result has been seen.
    task automatic drain_results();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic load_gate(input int row, input int col, input logic [3:0] gtype,
                             input int fanin, input int sa, input int sb,
                             input int sc, input int sd);
        t_cmd c;
        c = random_cmd(OP_LOAD);
        c.gate_row    = 3'(row);
        c.gate_col    = 3'(col);
        c.gate_type   = gtype;
        c.fanin_count = 3'(fanin);
        c.source_a    = IDX_W'(sa);
        c.source_b    = IDX_W'(sb);
        c.source_c    = IDX_W'(sc);
        c.source_d    = IDX_W'(sd);
        issue(c);
    endtask

    task automatic watch_output(input int row, input int col);
        t_cmd c;
        c = random_cmd(OP_APPEND);
        c.gate_row = 3'(row);
        c.gate_col = 3'(col);
        issue(c);
    endtask

    task automatic evaluate_fault(input logic [VEC_W-1:0] vec, input logic fen,
                                  input logic fval, input int row, input int col);
        t_cmd c;
        c = random_cmd(OP_EVAL);
        c.input_vector = vec;
        c.fault_enable = fen;
        c.fault_value  = fval;
        c.gate_row     = 3'(row);
        c.gate_col     = 3'(col);
        issue(c);
    endtask

    // Main stimulus: reset, directed circuit build and checks, then random traffic.
    initial begin
        t_cmd        c;
        int unsigned counted;
        int unsigned roll;
        int unsigned load_share;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Evaluate before any output exists.
        evaluate_fault(8'hA5, 1'b1, 1'b1, 0, 0);

        // Small circuit: four inputs feeding AND, NAND, XOR, NOT, XNOR and NOR gates.
        load_gate(0, 0, GT_INPUT, 0, 63, 63, 63, 63);
        load_gate(0, 1, GT_INPUT, 0, 63, 63, 63, 63);
        load_gate(0, 2, GT_INPUT, 0, 0, 0, 0, 0);
        load_gate(0, 3, GT_INPUT, 0, 0, 0, 0, 0);
        load_gate(1, 0, GT_AND, 2, 0, 1, 63, 63);
        load_gate(1, 1, GT_NAND, 3, 1, 2, 3, 63);
        // Rejected: a source in the same row, and any source at all in row 0.
        load_gate(1, 2, GT_OR, 2, 0, 8, 0, 0);
        load_gate(0, 4, GT_BUF, 1, 0, 0, 0, 0);
        // Fan-in beyond the limit saturates; unused sources are stored only.
        load_gate(2, 0, GT_XOR, 7, 8, 9, 0, 3);
        load_gate(2, 1, GT_NOT, 1, 8, 63, 63, 63);
        load_gate(3, 0, GT_XNOR, 2, 16, 17, 0, 0);
        load_gate(7, 6, GT_UNUSED_TOP, 0, 0, 0, 0, 0);
        // One source is an empty cell, which reads as unknown.
        load_gate(7, 7, GT_NOR, 4, 24, 8, 2, 55);

        // Fill the output list, including an empty site, then overflow it.
        watch_output(1, 0);
        watch_output(1, 1);
        watch_output(2, 0);
        watch_output(2, 1);
        watch_output(3, 0);
        watch_output(7, 7);
        watch_output(7, 6);
        watch_output(5, 5);
        watch_output(4, 4);

        // Fault off, fault on an empty site, stuck-at-0 and stuck-at-1.
        evaluate_fault(8'h00, 1'b0, 1'b0, 0, 0);
        evaluate_fault(8'hFF, 1'b1, 1'b0, 5, 5);
        evaluate_fault(8'hFF, 1'b1, 1'b0, 0, 0);
        evaluate_fault(8'h00, 1'b1, 1'b1, 1, 0);
        issue(random_cmd(OP_UNUSED));

        // Random traffic: mostly legal loads and evaluates, a little noise.
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if (counted % 25 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            if (counted >= RANDOM_ITEMS - CALM_TAIL) gaps_on = 1'b0;
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                issue(random_cmd(OP_UNUSED));
            end else begin
                load_share = (counted < 60) ? 80 : 45;
                roll = $urandom_range(0, 99);
                if (roll < load_share) begin
                    c = random_load($urandom_range(0, 9) != 0);
                end else if (roll < load_share + 3) begin
                    c = random_cmd(OP_APPEND);
                end else begin
                    c = random_eval();
                end
                issue(c);
                counted++;
                if (counted == RANDOM_ITEMS / 2) drain_results();
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("[stuck_at_fault_netlist_simulator] OK");
        end else begin
            $display("[stuck_at_fault_netlist_simulator] ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #LIMIT_NS;
        $display("[stuck_at_fault_netlist_simulator] ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/sfsim_pkg.sv
rtl/sfsim_gate_mem.sv
rtl/sfsim_val_mem.sv
rtl/sfsim_eval.sv
rtl/stuck_at_fault_netlist_simulator.sv
dv/sfsim_result_checker.sv
dv/tb.sv
